>>> rtl/slpf_pkg.sv
// Shared constants, types and mask curve ROM for the shadow lift pixel filter.
`default_nettype none

package slpf_pkg;

  localparam int MASK_TABLE_DEPTH = 256;
  localparam int DEPTH_LOG2 = $clog2(MASK_TABLE_DEPTH);
  localparam int IDX_W = $clog2(MASK_TABLE_DEPTH + 1);
  localparam int MASK_W = 17;
  localparam int BOOST_W = 15;

  localparam logic [15:0] LUMA_W_RED = 16'd19595;
  localparam logic [15:0] LUMA_W_GREEN = 16'd38470;
  localparam logic [15:0] LUMA_W_BLUE = 16'd7471;
  localparam logic [16:0] Q_HALF = 17'd32768;
  localparam logic [16:0] MASK_THRESHOLD = 17'd655;
  localparam logic signed [7:0] AMOUNT_MAX = 8'sd100;
  localparam logic signed [7:0] AMOUNT_MIN = -8'sd100;

  // ceil(2^32 / 255): exact floor division for sums below 2^24
  localparam logic [24:0] RECIP_255 = 25'd16843010;
  // ceil(2^35 / 1000): exact floor division for magnitudes below 2^25
  localparam logic [25:0] RECIP_1000 = 26'd34359739;

  typedef logic [MASK_W-1:0] mask_rom_t [0:MASK_TABLE_DEPTH];

  typedef struct packed {
    logic act;
    logic neg;
    logic [BOOST_W-1:0] mag;
  } boost_t;

  function automatic mask_rom_t build_mask_rom();
    mask_rom_t rom;
    longint unsigned n;
    longint unsigned res;
    longint unsigned b;
    longint unsigned i;
    for (int e = 0; e <= MASK_TABLE_DEPTH; e++) begin
      i = longint'(e);
      // depth is a power of two: divide by its cube with a shift
      n = ((i * i * i) << 32) >> (3 * DEPTH_LOG2);
      res = 0;
      for (int k = 31; k >= 0; k--) begin
        b = 64'd1 << (2 * k);
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
      end
      rom[e] = res[MASK_W-1:0];
    end
    return rom;
  endfunction

  localparam mask_rom_t MASK_ROM = build_mask_rom();

endpackage

`default_nettype wire

>>> rtl/shadow_lift_pixel_filter.sv
// Top level of the shadow lift pixel filter: seven-stage pixel pipeline.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  pixel in  | in_valid / in_stall        | red_in, green_in, blue_in, alpha_in
//  pixel out | out_valid / out_stall      | red_out, green_out, blue_out, alpha_out
//  config    | shadow_amount_we           | shadow_amount
//
// One request per clock while out_stall is low; out_valid rises once the request has passed every stage.
// Stages: weighted sum, luma divide, mask ROM, boost product, divide by 1000,
// channel product, sum and clamp. Per-stage load enables fill bubbles under a
// stall, so in_stall rises only once every stage holds a request.
// Synchronous reset clears the valid bits and sets the amount to zero (bypass).
`default_nettype none

module shadow_lift_pixel_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  red_in,
  input  wire logic [7:0]  green_in,
  input  wire logic [7:0]  blue_in,
  input  wire logic [7:0]  alpha_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out,
  output logic [7:0]       alpha_out,
  input  wire logic        shadow_amount_we,
  input  wire logic signed [7:0] shadow_amount
);
  import slpf_pkg::*;

  localparam int STAGES = 7;

  logic               amount_zero;
  logic signed [9:0]  amount_x3;
  logic signed [7:0]  amount_sat;
  logic signed [9:0]  amount_ext;

  logic [STAGES:1]    vld;
  logic [STAGES:1]    ld;

  logic [7:0]  r1, g1, b1, a1;
  logic [23:0] wsum1;
  logic [7:0]  r2, g2, b2, a2;
  logic [16:0] luma2;
  logic [7:0]  r3, g3, b3, a3;
  logic [MASK_W-1:0] mask3;
  logic [7:0]  r4, g4, b4, a4;
  logic        act4;
  logic signed [27:0] prod4;
  logic [7:0]  r5, g5, b5, a5;
  boost_t      boost5;
  logic [7:0]  a6, a7;

  logic [48:0] luma_prod;
  logic        dark;
  logic [16:0] dark_span;
  logic [31:0] idx_acc;
  logic [IDX_W-1:0] idx;
  logic [24:0] mag4;
  logic [50:0] div_prod;

  // amount register, saturated at write
  always_comb begin
    if (shadow_amount > AMOUNT_MAX) begin
      amount_sat = AMOUNT_MAX;
    end else if (shadow_amount < AMOUNT_MIN) begin
      amount_sat = AMOUNT_MIN;
    end else begin
      amount_sat = shadow_amount;
    end
    amount_ext = 10'(amount_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amount_zero <= 1'b1;
      amount_x3   <= 10'sd0;
    end else if (shadow_amount_we) begin
      amount_zero <= (amount_sat == 8'sd0);
      amount_x3   <= amount_ext + (amount_ext <<< 1);
    end
  end

  // load enables, from the output back
  always_comb begin
    ld[STAGES] = !vld[STAGES] || !out_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign in_stall  = !ld[1];
  assign out_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: weighted channel sum
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      r1 <= red_in;
      g1 <= green_in;
      b1 <= blue_in;
      a1 <= alpha_in;
      wsum1 <= 24'(LUMA_W_RED) * 24'(red_in) + 24'(LUMA_W_GREEN) * 24'(green_in)
             + 24'(LUMA_W_BLUE) * 24'(blue_in);
    end
  end

  // stage 2: luma = sum / 255
  assign luma_prod = 49'(wsum1) * 49'(RECIP_255);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      r2 <= r1;
      g2 <= g1;
      b2 <= b1;
      a2 <= a1;
      luma2 <= luma_prod[32 +: 17];
    end
  end

  // stage 3: darkness mask lookup
  assign dark      = luma2 < Q_HALF;
  assign dark_span = 17'((Q_HALF - luma2) << 1);
  assign idx_acc   = 32'(dark_span) * 32'(MASK_TABLE_DEPTH) + 32'(Q_HALF);
  assign idx       = idx_acc[16 +: IDX_W];

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      r3 <= r2;
      g3 <= g2;
      b3 <= b2;
      a3 <= a2;
      mask3 <= dark ? MASK_ROM[idx] : '0;
    end
  end

  // stage 4: amount * 3 * mask
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      r4 <= r3;
      g4 <= g3;
      b4 <= b3;
      a4 <= a3;
      act4 <= mask3 > MASK_THRESHOLD;
      prod4 <= 28'(amount_x3 * $signed({1'b0, mask3}));
    end
  end

  // stage 5: divide by 1000, truncate toward zero
  assign mag4     = prod4[27] ? 25'(-prod4) : prod4[24:0];
  assign div_prod = 51'(mag4) * 51'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      r5 <= r4;
      g5 <= g4;
      b5 <= b4;
      a5 <= a4;
      boost5.act <= act4;
      boost5.neg <= prod4[27];
      boost5.mag <= div_prod[35 +: BOOST_W];
    end
  end

  // stages 6 and 7: per-channel lift
  slpf_lift u_lift_red (
    .clk    (clk),
    .ld_mul (ld[6]),
    .ld_out (ld[7]),
    .chan   (r5),
    .boost  (boost5),
    .result (red_out)
  );

  slpf_lift u_lift_green (
    .clk    (clk),
    .ld_mul (ld[6]),
    .ld_out (ld[7]),
    .chan   (g5),
    .boost  (boost5),
    .result (green_out)
  );

  slpf_lift u_lift_blue (
    .clk    (clk),
    .ld_mul (ld[6]),
    .ld_out (ld[7]),
    .chan   (b5),
    .boost  (boost5),
    .result (blue_out)
  );

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      a6 <= a5;
    end
    if (ld[7]) begin
      a7 <= amount_zero ? a6 : 8'd255;
    end
  end

  assign alpha_out = a7;

endmodule

`default_nettype wire

>>> rtl/slpf_lift.sv
// One color channel of the lift: boost product stage and sum/clamp output stage.
`default_nettype none

module slpf_lift (
  input  wire logic                clk,
  input  wire logic                ld_mul,
  input  wire logic                ld_out,
  input  wire logic [7:0]          chan,
  input  wire slpf_pkg::boost_t    boost,
  output logic [7:0]               result
);
  import slpf_pkg::*;

  logic [7:0]         chan_m;
  logic               act_m;
  logic signed [24:0] prod_m;
  logic signed [15:0] boost_s;
  logic signed [8:0]  headroom;
  logic signed [25:0] sum;
  logic [7:0]         result_next;

  assign boost_s = boost.neg ? -$signed({1'b0, boost.mag}) : $signed({1'b0, boost.mag});
  assign headroom = $signed({1'b0, 8'(8'd255 - chan)});

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      chan_m <= chan;
      act_m  <= boost.act;
      prod_m <= 25'(boost_s * headroom);
    end
  end

  always_comb begin
    sum = $signed({2'b00, chan_m, 16'h0000}) + 26'(prod_m);
    if (!act_m) begin
      result_next = chan_m;
    end else if (sum[25] || sum == 26'sd0) begin
      result_next = 8'd0;
    end else if (sum[24]) begin
      result_next = 8'd255;
    end else begin
      result_next = sum[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_shadow_lift_pixel_filter.sv
// Self-checking testbench for shadow_lift_pixel_filter: pixel stream under varied lift amounts.
`timescale 1ns / 100ps

module tb_shadow_lift_pixel_filter;

  localparam int DEPTH = slpf_pkg::MASK_TABLE_DEPTH;
  localparam longint W_RED = 19595;
  localparam longint W_GREEN = 38470;
  localparam longint W_BLUE = 7471;
  localparam longint HALF_Q = 32768;
  localparam longint MASK_FLOOR = 655;
  localparam int AMOUNT_LIMIT = 100;
  localparam int PHASE_ITEMS = 70;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  class lift_scoreboard;
    logic signed [7:0] amount;
    rgba_t lifted_q[$];
    int unsigned failures;
    longint curve[0:DEPTH];

    function new();
      longint n;
      longint lo;
      longint hi;
      longint mid;
      amount = '0;
      failures = 0;
      for (longint i = 0; i <= DEPTH; i++) begin
        n = ((i * i * i) << 32) / (longint'(DEPTH) * DEPTH * DEPTH);
        lo = 0;
        hi = 65537;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          if (mid * mid <= n) lo = mid;
          else hi = mid - 1;
        end
        curve[i] = lo;
      end
    endfunction

    function logic [7:0] lift_channel(logic [7:0] c, longint boost);
      longint v;
      v = longint'(c) * 65536 + boost * (255 - longint'(c));
      if (v <= 0) return 8'd0;
      v = v >>> 16;
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function rgba_t lift_pixel(rgba_t p);
      int a;
      longint luma;
      longint d;
      longint idx;
      longint mask;
      longint boost;
      rgba_t q;
      a = amount;
      if (a > AMOUNT_LIMIT) a = AMOUNT_LIMIT;
      if (a < -AMOUNT_LIMIT) a = -AMOUNT_LIMIT;
      if (a == 0) return p;
      luma = (W_RED * p.red + W_GREEN * p.green + W_BLUE * p.blue) / 255;
      mask = 0;
      if (luma < HALF_Q) begin
        d = (HALF_Q - luma) * 2;
        idx = (d * DEPTH + 32768) >>> 16;
        mask = curve[idx];
      end
      q = p;
      q.alpha = 8'd255;
      if (mask > MASK_FLOOR) begin
        boost = (longint'(a) * mask * 3) / 1000;
        q.red = lift_channel(p.red, boost);
        q.green = lift_channel(p.green, boost);
        q.blue = lift_channel(p.blue, boost);
      end
      return q;
    endfunction

    function void note_pixel(rgba_t p);
      lifted_q.push_back(lift_pixel(p));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_pixel(rgba_t got);
      rgba_t want;
      if (lifted_q.size() == 0) begin
        $error("red_out: expected none, got %0d (unexpected result)", got.red);
        failures++;
        return;
      end
      want = lifted_q.pop_front();
      compare_field("red_out", want.red, got.red);
      compare_field("green_out", want.green, got.green);
      compare_field("blue_out", want.blue, got.blue);
      compare_field("alpha_out", want.alpha, got.alpha);
    endfunction

    function int pending();
      return lifted_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic [7:0] alpha_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic shadow_amount_we = 1'b0;
  logic signed [7:0] shadow_amount = '0;

  bit calm = 1'b0;
  lift_scoreboard sb = new();

  shadow_lift_pixel_filter u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .red_in           (red_in),
    .green_in         (green_in),
    .blue_in          (blue_in),
    .alpha_in         (alpha_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .red_out          (red_out),
    .green_out        (green_out),
    .blue_out         (blue_out),
    .alpha_out        (alpha_out),
    .shadow_amount_we (shadow_amount_we),
    .shadow_amount    (shadow_amount)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_pixel('{red_out, green_out, blue_out, alpha_out});
    end
  end

  // stall the result side in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_amount(logic signed [7:0] value);
    in_valid <= 1'b0;
    wait_drained();
    shadow_amount_we <= 1'b1;
    shadow_amount <= value;
    @(negedge clk);
    shadow_amount_we <= 1'b0;
    sb.amount = value;
  endtask

  task automatic push_pixel(rgba_t p);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    red_in <= p.red;
    green_in <= p.green;
    blue_in <= p.blue;
    alpha_in <= p.alpha;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  function automatic rgba_t random_pixel();
    rgba_t p;
    int base;
    p.alpha = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: begin
        p.red = 8'($urandom_range(0, 255));
        p.green = 8'($urandom_range(0, 255));
        p.blue = 8'($urandom_range(0, 255));
      end
      1: begin
        p.red = 8'($urandom_range(0, 127));
        p.green = 8'($urandom_range(0, 127));
        p.blue = 8'($urandom_range(0, 127));
      end
      default: begin
        // hover around the mask threshold
        base = $urandom_range(100, 140);
        p.red = 8'(base + $urandom_range(0, 8) - 4);
        p.green = 8'(base + $urandom_range(0, 8) - 4);
        p.blue = 8'(base + $urandom_range(0, 8) - 4);
      end
    endcase
    return p;
  endfunction

  task automatic run_random(int count);
    repeat (count) push_pixel(random_pixel());
  endtask

  initial begin
    rgba_t corner_px[12];
    logic signed [7:0] phase_amount[9];
    corner_px = '{
      '{8'd0, 8'd0, 8'd0, 8'h00},
      '{8'd255, 8'd255, 8'd255, 8'hFF},
      '{8'd255, 8'd0, 8'd0, 8'hAA},
      '{8'd0, 8'd255, 8'd0, 8'h55},
      '{8'd0, 8'd0, 8'd255, 8'h0F},
      '{8'd127, 8'd127, 8'd127, 8'hF0},
      '{8'd128, 8'd128, 8'd128, 8'h80},
      '{8'd120, 8'd120, 8'd120, 8'h01},
      '{8'd121, 8'd121, 8'd121, 8'hFE},
      '{8'd122, 8'd122, 8'd122, 8'h7F},
      '{8'd123, 8'd123, 8'd123, 8'h33},
      '{8'd30, 8'd60, 8'd10, 8'hCC}
    };
    phase_amount = '{8'sd127, -8'sd128, 8'sd1, -8'sd1, 8'sd101, -8'sd101, 8'sd0, 8'sd37,
                     8'($urandom_range(0, 255))};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset amount: bypass
    run_random(PHASE_ITEMS);

    write_amount(8'sd100);
    foreach (corner_px[i]) push_pixel(corner_px[i]);
    write_amount(-8'sd100);
    foreach (corner_px[i]) push_pixel(corner_px[i]);

    foreach (phase_amount[k]) begin
      write_amount(phase_amount[k]);
      if (k == $size(phase_amount) - 1) calm = 1'b1;
      run_random(PHASE_ITEMS);
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (20) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
